// ===== rtl/core/ufd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufd_pkg: shared types and constants of the UTF-8 stream decoder
// Error codes, the queue entry that passes a finished sequence from the
// front to the back, and the lead byte classifier.
// ----------------------------------------------------------------------------
package ufd_pkg;

    // Field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned ERR_W  = 3;
    localparam int unsigned LEN_W  = 3;
    localparam int unsigned SEEN_W = 2;

    // Configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_OUTPUT_FORM_ADDR = 3'h0;

    // Decoder queue depth
    localparam int unsigned QUEUE_DEPTH = 4;

    // Code point limits
    localparam logic [CP_W-1:0] CP_MIN_3BYTE   = 21'h000800;
    localparam logic [CP_W-1:0] CP_SUPP_BASE   = 21'h010000;
    localparam logic [CP_W-1:0] CP_UTF16_MAX   = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_HIGH_BASE = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_LOW_BASE  = 21'h00DC00;

    // Output form codes
    localparam logic FORM_UTF32 = 1'b0;
    localparam logic FORM_UTF16 = 1'b1;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_BAD_LEAD  = 3'd1,
        ERR_BAD_CONT  = 3'd2,
        ERR_OVERLONG  = 3'd3,
        ERR_TRUNCATED = 3'd4,
        ERR_RANGE     = 3'd5
    } t_err_code;

    // One finished sequence: a code point, an error, or a surrogate pair to split
    typedef struct packed {
        logic [CP_W-1:0] cp;
        t_err_code       err;
        logic            pair;
    } t_cp_item;

    // Sequence length for a lead byte; 0 means not a valid lead
    function automatic logic [LEN_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] n;
        begin
            if (b < 8'h80) begin
                n = 3'd1;
            end else if (b >= 8'hC2 && b < 8'hE0) begin
                n = 3'd2;
            end else if (b >= 8'hE0 && b < 8'hF0) begin
                n = 3'd3;
            end else if (b >= 8'hF0 && b < 8'hF8) begin
                n = 3'd4;
            end else begin
                n = 3'd0;
            end
            return n;
        end
    endfunction

endpackage

// ===== rtl/core/ufd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufd_front: byte intake and sequence tracking
// Accepts one byte per cycle while the queue has room, keeps the open
// sequence, pushes one entry per byte that ends a sequence or flags an error.
// ----------------------------------------------------------------------------
module ufd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [ufd_pkg::BYTE_W-1:0]  s_axis_tdata,
    input  logic                        s_axis_tlast,
    input  logic                        i_output_form,
    input  logic                        i_queue_full,
    output logic                        o_push,
    output ufd_pkg::t_cp_item           o_item
);
    import ufd_pkg::*;

    logic [BYTE_W-1:0] r_lead, n_lead;
    logic [LEN_W-1:0]  r_seq_len, n_seq_len;
    logic [SEEN_W-1:0] r_seen, n_seen;
    logic [CP_W-1:0]   r_pcp, n_pcp;

    logic              accept;
    logic              ev_valid;
    logic              ev_done;
    logic [CP_W-1:0]   ev_cp;
    t_err_code         ev_err;
    logic [LEN_W-1:0]  n_len_lead;
    logic [LEN_W-1:0]  seen_inc;
    logic [CP_W-1:0]   ext_pcp;
    logic              overlong;
    logic              utf16;

    assign s_axis_tready = !i_queue_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign n_len_lead    = lead_len(s_axis_tdata);
    assign seen_inc      = {1'b0, r_seen} + 3'd1;
    assign ext_pcp       = {r_pcp[CP_W-7:0], s_axis_tdata[5:0]};
    assign utf16         = (i_output_form == FORM_UTF16);

    // Classify the byte and update the open sequence
    always_comb begin
        n_lead    = r_lead;
        n_seq_len = r_seq_len;
        n_seen    = r_seen;
        n_pcp     = r_pcp;
        ev_valid  = 1'b0;
        ev_done   = 1'b0;
        ev_cp     = '0;
        ev_err    = ERR_NONE;
        if (r_seq_len == 3'd0) begin
            if (n_len_lead == 3'd0) begin
                ev_valid = 1'b1;
                ev_err   = ERR_BAD_LEAD;
            end else if (n_len_lead == 3'd1) begin
                ev_valid = 1'b1;
                ev_done  = 1'b1;
                ev_cp    = CP_W'(s_axis_tdata);
            end else if (s_axis_tlast) begin
                ev_valid = 1'b1;
                ev_err   = ERR_TRUNCATED;
            end else begin
                n_lead    = s_axis_tdata;
                n_seq_len = n_len_lead;
                n_seen    = 2'd1;
                case (n_len_lead)
                    3'd2:    n_pcp = CP_W'(s_axis_tdata[4:0]);
                    3'd3:    n_pcp = CP_W'(s_axis_tdata[3:0]);
                    default: n_pcp = CP_W'(s_axis_tdata[2:0]);
                endcase
            end
        end else if (s_axis_tdata[7:6] != 2'b10) begin
            // Drop the partial sequence together with the offending byte
            n_lead    = '0;
            n_seq_len = '0;
            n_seen    = '0;
            n_pcp     = '0;
            ev_valid  = 1'b1;
            ev_err    = ERR_BAD_CONT;
        end else if (seen_inc == r_seq_len) begin
            n_lead    = '0;
            n_seq_len = '0;
            n_seen    = '0;
            n_pcp     = '0;
            ev_valid  = 1'b1;
            ev_done   = 1'b1;
            ev_cp     = ext_pcp;
        end else if (s_axis_tlast) begin
            n_lead    = '0;
            n_seq_len = '0;
            n_seen    = '0;
            n_pcp     = '0;
            ev_valid  = 1'b1;
            ev_err    = ERR_TRUNCATED;
        end else begin
            n_seen = seen_inc[SEEN_W-1:0];
            n_pcp  = ext_pcp;
        end
    end

    // Check a finished code point for overlong form and against the output form
    always_comb begin
        overlong = ((r_seq_len == 3'd2) && ((r_lead & 8'h1E) == 8'h00)) ||
                   ((r_seq_len == 3'd3) && (ext_pcp < CP_MIN_3BYTE)) ||
                   ((r_seq_len == 3'd4) && (ext_pcp < CP_SUPP_BASE));
        o_item.cp   = ev_cp;
        o_item.err  = ev_err;
        o_item.pair = 1'b0;
        if (ev_done) begin
            if (r_seq_len != 3'd0 && overlong) begin
                o_item.cp  = '0;
                o_item.err = ERR_OVERLONG;
            end else if (utf16 && ev_cp > CP_UTF16_MAX) begin
                o_item.cp  = '0;
                o_item.err = ERR_RANGE;
            end else if (utf16 && ev_cp >= CP_SUPP_BASE) begin
                o_item.pair = 1'b1;
            end
        end
    end

    assign o_push = accept && ev_valid;

    // Hold sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead    <= '0;
            r_seq_len <= '0;
            r_seen    <= '0;
            r_pcp     <= '0;
        end else if (accept) begin
            r_lead    <= n_lead;
            r_seq_len <= n_seq_len;
            r_seen    <= n_seen;
            r_pcp     <= n_pcp;
        end
    end

endmodule

// ===== rtl/core/ufd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufd_queue: small register queue between front and back
// Holds finished sequences so intake and output stall independently.
// ----------------------------------------------------------------------------
module ufd_queue #(
    parameter int unsigned P_DEPTH = ufd_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ufd_pkg::t_cp_item i_item,
    input  logic              i_pop,
    output ufd_pkg::t_cp_item o_head,
    output logic              o_empty,
    output logic              o_full
);
    import ufd_pkg::*;

    localparam int unsigned PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(P_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(P_DEPTH);

    t_cp_item         r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_FULL);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // Write entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/ufd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufd_back: result formatting and output register
// Pops finished sequences, splits supplementary code points into a
// surrogate pair, and drives the registered output beat.
// ----------------------------------------------------------------------------
module ufd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ufd_pkg::t_cp_item           i_head,
    input  logic                        i_empty,
    output logic                        o_pop,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [ufd_pkg::CP_W-1:0]    m_axis_tdata,
    output logic [ufd_pkg::ERR_W-1:0]   m_axis_tuser,
    output logic                        m_axis_tlast
);
    import ufd_pkg::*;

    logic            r_out_valid;
    logic [CP_W-1:0] r_out_unit;
    t_err_code       r_out_err;
    logic            r_out_last;
    logic            r_pend_valid;
    logic [CP_W-1:0] r_pend_unit;

    logic            out_free;
    logic [CP_W-1:0] supp;
    logic [CP_W-1:0] high_unit;
    logic [CP_W-1:0] low_unit;

    assign out_free  = !r_out_valid || m_axis_tready;
    assign o_pop     = out_free && !r_pend_valid && !i_empty;
    assign supp      = i_head.cp - CP_SUPP_BASE;
    assign high_unit = SURR_HIGH_BASE + CP_W'(supp[19:10]);
    assign low_unit  = SURR_LOW_BASE + CP_W'(supp[9:0]);

    // Load the output beat: pending low unit first, then the queue head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (out_free) begin
            if (r_pend_valid) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (!i_empty) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= i_head.pair;
            end else begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend_valid) begin
                r_out_unit <= r_pend_unit;
                r_out_err  <= ERR_NONE;
                r_out_last <= 1'b1;
            end else if (!i_empty) begin
                r_out_unit  <= i_head.pair ? high_unit : i_head.cp;
                r_out_err   <= i_head.err;
                r_out_last  <= !i_head.pair;
                r_pend_unit <= low_unit;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_unit;
    assign m_axis_tuser  = r_out_err;
    assign m_axis_tlast  = r_out_last;

    // A pending low unit only exists behind a shown high unit
    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_out_valid && !r_out_last))
        else $error("low surrogate pending without high unit on output");

    // A taken high unit is followed by its low unit as the final beat
    a_pair_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && m_axis_tready && !r_out_last) |=> (r_out_valid && r_out_last))
        else $error("surrogate pair not completed");

    // Error beats carry a zero unit and close the run
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err != ERR_NONE) |-> (r_out_last && r_out_unit == '0))
        else $error("error beat with data or without last");

    // The queue is never popped while the low unit is still pending
    a_no_pop_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> !o_pop)
        else $error("queue popped while low surrogate pending");

endmodule

// ===== rtl/core/utf8_stream_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top: UTF-8 to UTF-32 / UTF-16 stream decoder
// Byte stream in, code points or UTF-16 units out, with per-beat error codes.
// ----------------------------------------------------------------------------
// The decoder takes one UTF-8 byte per cycle on s_axis and keeps taking bytes
// back to back while results wait on m_axis. s_axis_tready drops only while
// the internal queue is full, that is while P_QUEUE_DEPTH finished sequences
// wait behind the one held in the output register. A result passes through
// the queue and then the output register. Each finished sequence gives one
// beat, except a supplementary code point in UTF-16 form, which gives two
// beats (high surrogate, then low with tlast); since such a code point needs
// four input bytes, the sustained rate stays one byte per cycle while
// m_axis is ready. Errors give one beat with a zero unit, the code on tuser
// and tlast set; the partial sequence is discarded. output_form is sampled
// when a sequence finishes, so change it only while the stream is idle.
module utf8_stream_decoder_top #(
    parameter int unsigned P_QUEUE_DEPTH = ufd_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Byte stream in
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] in_byte
    input  logic                            s_axis_tlast,  // end_of_stream
    // Decoded stream out
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [23:0]                     m_axis_tdata,  // [20:0] code_unit, rest zero
    output logic [2:0]                      m_axis_tuser,  // [2:0] error_code
    output logic                            m_axis_tlast,  // last_of_run
    // Configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ufd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ufd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ufd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import ufd_pkg::*;

    logic            r_output_form;
    logic            cfg_write;
    logic            push, pop, q_empty, q_full;
    t_cp_item        push_item, head_item;
    logic [CP_W-1:0] out_unit;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_form <= FORM_UTF32;
        end else if (cfg_write && paddr == REG_OUTPUT_FORM_ADDR) begin
            r_output_form <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_OUTPUT_FORM_ADDR) begin
            prdata[0] = r_output_form;
        end
    end

    ufd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .i_output_form  (r_output_form),
        .i_queue_full   (q_full),
        .o_push         (push),
        .o_item         (push_item)
    );

    ufd_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head_item),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    ufd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_item),
        .i_empty        (q_empty),
        .o_pop          (pop),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (out_unit),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_unit};

endmodule
